### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the key repeat block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KARA_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("key repeat assertion failed");

// Next-cycle implication, disabled during reset.
`define KARA_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("key repeat assertion failed");

`endif

### rtl/kara_pkg.sv
// ---------------------------------------------------------------------------
// kara_pkg
// Types and constants of the accelerating key auto-repeat block.
// ---------------------------------------------------------------------------
package kara_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_AFTER    = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_INTERVAL = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_INTERVAL = 4'd3;

   localparam logic [15:0] FIRST_DELAY_RST   = 16'd500;
   localparam logic [15:0] FAST_AFTER_RST    = 16'd1500;
   localparam logic [15:0] SLOW_INTERVAL_RST = 16'd120;
   localparam logic [15:0] FAST_INTERVAL_RST = 16'd60;

   localparam logic [1:0] ACT_PRESS   = 2'd0;
   localparam logic [1:0] ACT_HOLD    = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;
   localparam logic [1:0] ACT_CANCEL  = 2'd3;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_PRESS  = 2'd1;
   localparam logic [1:0] EV_REPEAT = 2'd2;

   typedef struct packed {
      logic [15:0] first_delay_ms;
      logic [15:0] fast_after_ms;
      logic [15:0] slow_interval_ms;
      logic [15:0] fast_interval_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        direction;
      logic [31:0] now_ms;
      logic        key_held;
      logic        debounce_busy;
   } req_type;

   typedef struct packed {
      logic [31:0] press_time;
      logic [31:0] last_repeat_time;
      logic        repeat_active;
      logic        repeat_started;
   } chan_state_type;

   typedef struct packed {
      logic [1:0] key_event;
      logic       event_direction;
   } rsp_type;

endpackage

### rtl/kara_decide.sv
// ---------------------------------------------------------------------------
// kara_decide
// Event decision for one request against the state of its direction.
// ---------------------------------------------------------------------------
module kara_decide
   import kara_pkg::*;
(
   input  req_type        req,
   input  cfg_type        cfg,
   input  chan_state_type cur,
   output chan_state_type nxt,
   output logic           clear_all,
   output rsp_type        rsp
);

   logic [31:0] elapsed;
   logic [31:0] since;
   logic [15:0] interval;
   logic [1:0]  ev;

   // Wrapping differences, exactly as a modulo 2^32 subtraction.
   assign elapsed  = req.now_ms - cur.press_time;
   assign since    = req.now_ms - cur.last_repeat_time;
   assign interval = (elapsed >= {16'd0, cfg.fast_after_ms}) ?
                     cfg.fast_interval_ms : cfg.slow_interval_ms;

   always_comb begin
      nxt       = cur;
      clear_all = 1'b0;
      ev        = EV_NONE;
      unique case (req.action)
         ACT_PRESS: begin
            nxt.press_time       = req.now_ms;
            nxt.last_repeat_time = req.now_ms;
            nxt.repeat_active    = 1'b1;
            nxt.repeat_started   = 1'b0;
            ev                   = EV_PRESS;
         end
         ACT_HOLD: begin
            if (cur.repeat_active && req.key_held && !req.debounce_busy &&
                (elapsed >= {16'd0, cfg.first_delay_ms})) begin
               // The first repeat ignores the interval; later ones wait it out.
               if (!(cur.repeat_started && (since < {16'd0, interval}))) begin
                  nxt.repeat_started   = 1'b1;
                  nxt.last_repeat_time = req.now_ms;
                  ev                   = EV_REPEAT;
               end
            end
         end
         ACT_RELEASE: begin
            nxt.repeat_active = 1'b0;
         end
         ACT_CANCEL: begin
            clear_all = 1'b1;
         end
         default: begin
            clear_all = 1'b0;
         end
      endcase
   end

   assign rsp.key_event       = ev;
   assign rsp.event_direction = (ev != EV_NONE) ? req.direction : 1'b0;

endmodule

### rtl/key_auto_repeat_accelerating_core.sv
// ---------------------------------------------------------------------------
// key_auto_repeat_accelerating_core
// Two-direction key auto-repeat with a slow and a fast repeat interval.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_tvalid/tready    tuser: action, direction;
//                                           tdata: now_ms, key_held, busy
//  rsp      out        rsp_tvalid/tready    tdata: key_event; tuser: direction
//  csr      in         csr_we               csr_index, csr_wdata
//
//  One request per cycle while req_tready is high; each request gives exactly
//  one response, registered in the output or the skid register. The path is set
//  by the two 32-bit subtractions and compares in the decision logic.
//  Reset clears the configuration to its defaults and all directions to
//  inactive. A stalled response waits in the output register while one more
//  request is taken into a skid register; req_tready drops while it is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module key_auto_repeat_accelerating_core
   import kara_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [39:0]           req_tdata,  // now_ms, key_held, debounce_busy, zero fill
   input  logic [2:0]            req_tuser,  // action, direction
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // key_event, zero fill
   output logic [0:0]            rsp_tuser,  // event_direction
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff;
   chan_state_type state_ff [2];
   rsp_type        out_ff;
   rsp_type        skid_ff;
   logic           out_valid_ff;
   logic           skid_valid_ff;

   req_type        req;
   chan_state_type cur;
   chan_state_type nxt;
   logic           clear_all;
   rsp_type        res;
   logic           req_accept;
   logic           rsp_take;

   assign req.action        = req_tuser[1:0];
   assign req.direction     = req_tuser[2];
   assign req.now_ms        = req_tdata[31:0];
   assign req.key_held      = req_tdata[32];
   assign req.debounce_busy = req_tdata[33];

   assign cur = state_ff[req.direction];

   kara_decide u_decide (
      .req       (req),
      .cfg       (cfg_ff),
      .cur       (cur),
      .nxt       (nxt),
      .clear_all (clear_all),
      .rsp       (res)
   );

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_take   = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay_ms   <= FIRST_DELAY_RST;
         cfg_ff.fast_after_ms    <= FAST_AFTER_RST;
         cfg_ff.slow_interval_ms <= SLOW_INTERVAL_RST;
         cfg_ff.fast_interval_ms <= FAST_INTERVAL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_DELAY:   cfg_ff.first_delay_ms   <= csr_wdata;
            CSR_FAST_AFTER:    cfg_ff.fast_after_ms    <= csr_wdata;
            CSR_SLOW_INTERVAL: cfg_ff.slow_interval_ms <= csr_wdata;
            CSR_FAST_INTERVAL: cfg_ff.fast_interval_ms <= csr_wdata;
            default:           cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int d = 0; d < 2; d++) begin
         if (reset) begin
            state_ff[d] <= '0;
         end else if (req_accept) begin
            if (clear_all) begin
               state_ff[d] <= '0;
            end else if (req.direction == 1'(d)) begin
               state_ff[d] <= nxt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_accept;
         end
      end else if (req_accept) begin
         if (out_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take && skid_valid_ff) begin
         out_ff <= skid_ff;
      end else if (req_accept && (rsp_take || !out_valid_ff)) begin
         out_ff <= res;
      end
      if (req_accept && out_valid_ff && !rsp_take) begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {6'd0, out_ff.key_event};
   assign rsp_tuser[0] = out_ff.event_direction;

   `KARA_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `KARA_ASSERT_NXT(a_press_activates, clock, reset, req_accept && (req.action == ACT_PRESS),
      state_ff[$past(req.direction)].repeat_active)
   `KARA_ASSERT_NXT(a_cancel_clears, clock, reset, req_accept && (req.action == ACT_CANCEL),
      !state_ff[0].repeat_active && !state_ff[1].repeat_active)
   `KARA_ASSERT_IMP(a_repeat_needs_active, clock, reset,
      req_accept && (res.key_event == EV_REPEAT), cur.repeat_active)

endmodule

### tb/key_auto_repeat_accelerating_core_tb.sv
// ---------------------------------------------------------------------------
// key_auto_repeat_accelerating_core_tb
// Self-checking bench for the two-direction key auto-repeat block. Press,
// hold, release and cancel requests are driven over the request stream with
// random idle bursts and response stalls. A scoreboard keeps its own copy of
// the repeat timing state and checks every response in order.
// ---------------------------------------------------------------------------
module key_auto_repeat_accelerating_core_tb;
   import kara_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;

   class key_repeat_scoreboard;
      cfg_type        cfg;
      chan_state_type chan [2];
      rsp_type        expected_q [$];
      int unsigned    mismatch_count;

      function new();
         cfg.first_delay_ms   = FIRST_DELAY_RST;
         cfg.fast_after_ms    = FAST_AFTER_RST;
         cfg.slow_interval_ms = SLOW_INTERVAL_RST;
         cfg.fast_interval_ms = FAST_INTERVAL_RST;
         chan[0] = '0;
         chan[1] = '0;
         mismatch_count = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_FIRST_DELAY:   cfg.first_delay_ms   = val;
            CSR_FAST_AFTER:    cfg.fast_after_ms    = val;
            CSR_SLOW_INTERVAL: cfg.slow_interval_ms = val;
            CSR_FAST_INTERVAL: cfg.fast_interval_ms = val;
            default: ;
         endcase
      endfunction

      // Applies one request to the timing state and returns the key event it gives.
      function rsp_type next_key_event(req_type r);
         rsp_type     res;
         int          d;
         logic [31:0] elapsed;
         logic [31:0] since;
         logic [31:0] interval;
         res = '0;
         d = r.direction;
         case (r.action)
            ACT_PRESS: begin
               chan[d].press_time       = r.now_ms;
               chan[d].last_repeat_time = r.now_ms;
               chan[d].repeat_active    = 1'b1;
               chan[d].repeat_started   = 1'b0;
               res.key_event       = EV_PRESS;
               res.event_direction = r.direction;
            end
            ACT_HOLD: begin
               if (chan[d].repeat_active && r.key_held && !r.debounce_busy) begin
                  elapsed = r.now_ms - chan[d].press_time;
                  if (elapsed >= {16'd0, cfg.first_delay_ms}) begin
                     interval = (elapsed >= {16'd0, cfg.fast_after_ms}) ?
                                {16'd0, cfg.fast_interval_ms} : {16'd0, cfg.slow_interval_ms};
                     since = r.now_ms - chan[d].last_repeat_time;
                     if (!(chan[d].repeat_started && since < interval)) begin
                        chan[d].repeat_started   = 1'b1;
                        chan[d].last_repeat_time = r.now_ms;
                        res.key_event       = EV_REPEAT;
                        res.event_direction = r.direction;
                     end
                  end
               end
            end
            ACT_RELEASE: chan[d].repeat_active = 1'b0;
            default: begin
               chan[0] = '0;
               chan[1] = '0;
            end
         endcase
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(next_key_event(r));
      endfunction

      function void report(string what);
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("ERROR: %s", what);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response ev=%0d dir=%0d with no request pending",
                             got.key_event, got.event_direction));
            return;
         end
         want = expected_q.pop_front();
         if (got.key_event !== want.key_event)
            report($sformatf("key_event expected %0d actual %0d",
                             want.key_event, got.key_event));
         if (got.event_direction !== want.event_direction)
            report($sformatf("event_direction expected %0d actual %0d",
                             want.event_direction, got.event_direction));
      endfunction

      function void check_drained();
         if (expected_q.size() != 0)
            report($sformatf("%0d responses never arrived", expected_q.size()));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [39:0]           req_tdata = '0;  // now_ms, key_held, debounce_busy, zero fill
   logic [2:0]            req_tuser = '0;  // action, direction
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;       // key_event, zero fill
   logic [0:0]            rsp_tuser;       // event_direction
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   key_repeat_scoreboard repeat_sb = new();
   int unsigned cycle_count = 0;
   int unsigned requests_sent = 0;
   bit          idling_on = 1'b1;
   logic [31:0] tick_ms;

   key_auto_repeat_accelerating_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("key_auto_repeat_accelerating_core verification failed");
         $finish;
      end
   end

   // Observes handshakes and register writes with the values from before the edge.
   always @(posedge clock) begin
      req_type seen_req;
      rsp_type seen_rsp;
      if (!reset) begin
         if (csr_we)
            repeat_sb.write_reg(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            seen_req.action        = req_tuser[1:0];
            seen_req.direction     = req_tuser[2];
            seen_req.now_ms        = req_tdata[31:0];
            seen_req.key_held      = req_tdata[32];
            seen_req.debounce_busy = req_tdata[33];
            repeat_sb.note_request(seen_req);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp.key_event       = rsp_tdata[1:0];
            seen_rsp.event_direction = rsp_tuser[0];
            repeat_sb.check_response(seen_rsp);
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_event(input logic [1:0] action, input logic dir,
                             input logic [31:0] now, input logic held, input logic busy);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {dir, action};
      req_tdata  <= {6'd0, busy, held, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Lets every pending response drain so the registers can be changed safely.
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (repeat_sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_register(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_timing(input logic [15:0] first_delay, input logic [15:0] fast_after,
                                 input logic [15:0] slow_iv, input logic [15:0] fast_iv);
      wait_quiet();
      // An index past the last register must leave the settings alone.
      set_register(CSR_IDX_W'($urandom_range(4, 15)), 16'($urandom));
      set_register(CSR_FIRST_DELAY, first_delay);
      set_register(CSR_FAST_AFTER, fast_after);
      set_register(CSR_SLOW_INTERVAL, slow_iv);
      set_register(CSR_FAST_INTERVAL, fast_iv);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic advance_ticks();
      int unsigned pick;
      int unsigned coarse;
      pick = $urandom_range(0, 29);
      coarse = repeat_sb.cfg.fast_after_ms / 8 + repeat_sb.cfg.slow_interval_ms / 2 + 2;
      if (pick == 0)
         tick_ms += $urandom;
      else if (pick < 8)
         tick_ms += $urandom_range(0, repeat_sb.cfg.fast_interval_ms + 2);
      else
         tick_ms += $urandom_range(0, coarse);
   endtask

   // A press followed by a run of polls and usually a release, with the other
   // key poked now and then.
   task automatic play_key_hold();
      logic dir;
      int   polls;
      dir = 1'($urandom);
      send_event(ACT_PRESS, dir, tick_ms, 1'($urandom), 1'($urandom));
      polls = $urandom_range(2, 30);
      repeat (polls) begin
         advance_ticks();
         if ($urandom_range(0, 9) == 0)
            send_event(2'($urandom_range(0, 2)), ~dir, tick_ms, 1'b1, 1'b0);
         else
            send_event(ACT_HOLD, dir, tick_ms, $urandom_range(0, 9) != 0,
                       $urandom_range(0, 9) == 0);
      end
      case ($urandom_range(0, 9))
         0: send_event(ACT_CANCEL, 1'($urandom), tick_ms, 1'($urandom), 1'($urandom));
         1, 2: ;
         default: send_event(ACT_RELEASE, dir, tick_ms, 1'($urandom), 1'($urandom));
      endcase
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned target;
      target = requests_sent + count;
      while (requests_sent < target) begin
         if ($urandom_range(0, 9) < 8)
            play_key_hold();
         else
            repeat ($urandom_range(1, 4))
               send_event(2'($urandom), 1'($urandom), $urandom, 1'($urandom), 1'($urandom));
      end
   endtask

   task automatic run_directed();
      logic [31:0] t0;
      t0 = 32'hFFFF_FF00;
      send_event(ACT_HOLD,    1'b0, t0,          1'b1, 1'b0);  // not yet pressed
      send_event(ACT_PRESS,   1'b0, t0,          1'b0, 1'b0);
      send_event(ACT_HOLD,    1'b0, t0 + 100,    1'b1, 1'b0);  // inside first delay
      send_event(ACT_HOLD,    1'b0, t0 + 500,    1'b0, 1'b0);  // key not held
      send_event(ACT_HOLD,    1'b0, t0 + 500,    1'b1, 1'b1);  // still debouncing
      send_event(ACT_HOLD,    1'b0, t0 + 500,    1'b1, 1'b0);  // first repeat, across wrap
      send_event(ACT_HOLD,    1'b0, t0 + 619,    1'b1, 1'b0);  // one short of slow spacing
      send_event(ACT_HOLD,    1'b0, t0 + 620,    1'b1, 1'b0);
      send_event(ACT_HOLD,    1'b0, t0 + 1500,   1'b1, 1'b0);  // fast interval from here
      send_event(ACT_HOLD,    1'b0, t0 + 1559,   1'b1, 1'b0);
      send_event(ACT_HOLD,    1'b0, t0 + 1560,   1'b1, 1'b0);
      send_event(ACT_PRESS,   1'b1, 32'd0,       1'b1, 1'b1);
      send_event(ACT_HOLD,    1'b1, 32'd500,     1'b1, 1'b0);
      send_event(ACT_RELEASE, 1'b0, t0 + 1600,   1'b1, 1'b0);
      send_event(ACT_HOLD,    1'b0, t0 + 1700,   1'b1, 1'b0);  // released
      send_event(ACT_PRESS,   1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_event(ACT_CANCEL,  1'b1, 32'd600,     1'b1, 1'b1);
      send_event(ACT_HOLD,    1'b1, 32'd700,     1'b1, 1'b0);  // cancelled
      send_event(ACT_HOLD,    1'b0, 32'd5000,    1'b1, 1'b0);
      send_event(ACT_RELEASE, 1'b1, 32'd5000,    1'b0, 1'b0);  // release while inactive
      send_event(ACT_PRESS,   1'b1, 32'h8000_0000, 1'b1, 1'b0);
      send_event(ACT_HOLD,    1'b1, 32'h0000_0000, 1'b1, 1'b0);
      send_event(ACT_CANCEL,  1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1);
   endtask

   initial begin
      tick_ms = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(230);

      program_timing(16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                     16'($urandom_range(0, 30)), 16'($urandom_range(0, 15)));
      run_random(230);

      program_timing(16'd0, 16'd0, 16'd0, 16'd0);
      run_random(230);

      program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_random(230);

      // Fast threshold ahead of the first delay: the fast spacing applies at once.
      program_timing(16'($urandom_range(100, 400)), 16'($urandom_range(0, 99)),
                     16'($urandom_range(50, 200)), 16'($urandom_range(0, 40)));
      run_random(230);

      program_timing(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      run_random(230);

      program_timing(FIRST_DELAY_RST, FAST_AFTER_RST, SLOW_INTERVAL_RST, FAST_INTERVAL_RST);
      idling_on = 1'b0;
      run_random(230);

      wait_quiet();
      repeat (4) @(posedge clock);
      repeat_sb.check_drained();
      if (repeat_sb.mismatch_count == 0)
         $display("key_auto_repeat_accelerating_core verification clean");
      else
         $display("key_auto_repeat_accelerating_core verification failed");
      $finish;
   end

endmodule
